// File: rtl/core/tea_pkg.sv
// tea_pkg: shared types and codes of the triangle edge adjacency block
// depends on nothing; imported by every module of the block but tea_ram
package tea_pkg;

	// operation codes of an input item
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// status codes of a result item
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NO_FACE  = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] corner_a;
		logic [15:0] corner_b;
		logic [15:0] corner_c;
		logic [11:0] query_face;
	} in_item_t;

	typedef struct packed {
		logic [11:0] face_number;
		logic [12:0] neighbour_edge0;
		logic [12:0] neighbour_edge1;
		logic [12:0] neighbour_edge2;
		logic [1:0]  status;
	} out_item_t;

	typedef enum logic [1:0] {
		CK_CLEAR,
		CK_APPEND,
		CK_QUERY,
		CK_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] corner_a;
		logic [15:0] corner_b;
		logic [15:0] corner_c;
		logic [11:0] query_face;
	} cmd_t;

	// front to back link
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_link_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_QLOAD,
		BK_SCAN
	} bk_state_t;

endpackage

// File: rtl/core/tea_ram.sv
// tea_ram: generic single write, single read ram with registered read
// depends on nothing
module tea_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/tea_front.sv
// tea_front: accepts items, classifies the operation, holds a two entry queue
// depends on tea_pkg
module tea_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  tea_pkg::in_item_t  item,
	output tea_pkg::cmd_link_t link,
	input  logic               cmd_pop
);
	import tea_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       wr_en;
	logic       rd_en;

	always_comb begin
		cls.corner_a   = item.corner_a;
		cls.corner_b   = item.corner_b;
		cls.corner_c   = item.corner_c;
		cls.query_face = item.query_face;
		case (item.operation)
			OP_CLEAR:  cls.kind = CK_CLEAR;
			OP_APPEND: cls.kind = CK_APPEND;
			OP_READ:   cls.kind = CK_QUERY;
			default:   cls.kind = CK_NOP;
		endcase
	end

	assign full       = cnt_q == 2'd2;
	assign wr_en      = push && !full;
	assign rd_en      = cmd_pop && (cnt_q != 2'd0);
	assign link.valid = cnt_q != 2'd0;
	assign link.cmd   = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// File: rtl/core/tea_back.sv
// tea_back: carries out clear, append and neighbour read against the face ram
// depends on tea_pkg and tea_ram
module tea_back #(
	parameter int MAX_FACES   = 4096,
	parameter int VERTEX_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tea_pkg::cmd_link_t link,
	output logic               cmd_pop,
	output logic               empty,
	input  logic               pop,
	output tea_pkg::out_item_t result
);
	import tea_pkg::*;

	localparam int FW = $clog2(MAX_FACES);
	localparam int CW = FW + 1;
	localparam int VB = VERTEX_BITS;
	localparam int KW = 2 * VB;
	localparam logic [31:0] NONE32 = 32'(MAX_FACES);
	localparam logic [12:0] NONE13 = NONE32[12:0];

	function automatic logic [12:0] face13(input logic [FW-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[12:0];
	endfunction

	function automatic logic [11:0] face12(input logic [FW-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[11:0];
	endfunction

	function automatic logic [KW-1:0] pkey(input logic [VB-1:0] p, input logic [VB-1:0] q);
		return (p < q) ? {p, q} : {q, p};
	endfunction

	bk_state_t state_q, state_d;

	logic [CW-1:0]   count_q;
	logic [CW-1:0]   gi_q;
	logic            vld_s1;
	logic [FW-1:0]   g_s1;
	logic [FW-1:0]   qf_q;
	logic [KW-1:0]   qkey_q [3];
	logic [2:0]      pv_q, sv_q;
	logic [FW-1:0]   pf_q [3];
	logic [FW-1:0]   sf_q [3];
	out_item_t       res_q;
	logic            res_v_q;

	logic            we;
	logic [FW-1:0]   raddr;
	logic [3*VB-1:0] wdata;
	logic [3*VB-1:0] rdata;
	logic            slot_free;
	logic            go;
	logic            res_load;
	out_item_t       res_d;
	logic            st_full;
	logic            q_absent;
	logic            scan_done;
	logic [31:0]     ca32, cb32, cc32, q32;
	logic [KW-1:0]   gkey [3];
	logic [VB-1:0]   gc [3];
	logic [VB-1:0]   qc [3];

	tea_ram #(.WIDTH(3 * VB), .DEPTH(MAX_FACES)) u_faces (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[FW-1:0]),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign ca32      = 32'(link.cmd.corner_a);
	assign cb32      = 32'(link.cmd.corner_b);
	assign cc32      = 32'(link.cmd.corner_c);
	assign q32       = 32'(link.cmd.query_face);
	assign wdata     = {cc32[VB-1:0], cb32[VB-1:0], ca32[VB-1:0]};
	assign st_full   = count_q == CW'(MAX_FACES);
	assign q_absent  = q32 >= 32'(count_q);
	assign slot_free = !res_v_q || pop;
	assign scan_done = !vld_s1 && (gi_q == count_q);
	assign empty     = !res_v_q;
	assign result    = res_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			gc[i] = rdata[i*VB +: VB];
			qc[i] = rdata[i*VB +: VB];
		end
		for (int i = 0; i < 3; i++) begin
			gkey[i] = pkey(gc[i], gc[(i + 1) % 3]);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (link.valid && slot_free && link.cmd.kind == CK_QUERY && !q_absent) begin
					state_d = BK_QLOAD;
				end
			end
			BK_QLOAD: state_d = BK_SCAN;
			BK_SCAN: begin
				if (scan_done) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		go       = 1'b0;
		we       = 1'b0;
		raddr    = gi_q[FW-1:0];
		res_load = 1'b0;
		res_d.face_number     = '0;
		res_d.neighbour_edge0 = NONE13;
		res_d.neighbour_edge1 = NONE13;
		res_d.neighbour_edge2 = NONE13;
		res_d.status          = ST_OK;
		case (state_q)
			BK_IDLE: begin
				go    = link.valid && slot_free;
				raddr = q32[FW-1:0];
				if (go) begin
					case (link.cmd.kind)
						CK_APPEND: begin
							res_load = 1'b1;
							if (st_full) begin
								res_d.status = ST_FULL;
							end else begin
								we                = 1'b1;
								res_d.face_number = face12(count_q[FW-1:0]);
							end
						end
						CK_QUERY: begin
							if (q_absent) begin
								res_load          = 1'b1;
								res_d.face_number = link.cmd.query_face;
								res_d.status      = ST_NO_FACE;
							end
						end
						default: res_load = 1'b1;
					endcase
				end
			end
			BK_SCAN: begin
				if (scan_done) begin
					res_load          = 1'b1;
					res_d.face_number = face12(qf_q);
					res_d.neighbour_edge0 = sv_q[0] ? face13(sf_q[0]) :
						pv_q[0] ? face13(pf_q[0]) : NONE13;
					res_d.neighbour_edge1 = sv_q[1] ? face13(sf_q[1]) :
						pv_q[1] ? face13(pf_q[1]) : NONE13;
					res_d.neighbour_edge2 = sv_q[2] ? face13(sf_q[2]) :
						pv_q[2] ? face13(pf_q[2]) : NONE13;
				end
			end
			default: ;
		endcase
	end

	assign cmd_pop = go;

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
		if (state_q == BK_IDLE && go) begin
			qf_q <= q32[FW-1:0];
		end
		if (state_q == BK_QLOAD) begin
			for (int i = 0; i < 3; i++) begin
				qkey_q[i] <= pkey(qc[i], qc[(i + 1) % 3]);
			end
		end
		g_s1 <= gi_q[FW-1:0];
		if (state_q == BK_SCAN && vld_s1) begin
			for (int s = 0; s < 3; s++) begin
				for (int t = 0; t < 3; t++) begin
					if (qkey_q[s] == gkey[t]) begin
						if (g_s1 < qf_q || (g_s1 == qf_q && t < s)) begin
							pf_q[s] <= g_s1;
						end else if (!sv_q[s] && (g_s1 > qf_q || t > s)) begin
							sf_q[s] <= g_s1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			count_q <= '0;
			gi_q    <= '0;
			vld_s1  <= 1'b0;
			pv_q    <= '0;
			sv_q    <= '0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				res_v_q <= 1'b1;
			end else if (pop) begin
				res_v_q <= 1'b0;
			end
			if (go && link.cmd.kind == CK_CLEAR) begin
				count_q <= '0;
			end else if (we) begin
				count_q <= count_q + CW'(1);
			end
			case (state_q)
				BK_QLOAD: begin
					gi_q   <= '0;
					vld_s1 <= 1'b0;
					pv_q   <= '0;
					sv_q   <= '0;
				end
				BK_SCAN: begin
					if (gi_q != count_q) begin
						gi_q   <= gi_q + CW'(1);
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1) begin
						for (int s = 0; s < 3; s++) begin
							for (int t = 0; t < 3; t++) begin
								if (qkey_q[s] == gkey[t]) begin
									if (g_s1 < qf_q || (g_s1 == qf_q && t < s)) begin
										pv_q[s] <= 1'b1;
									end else if (g_s1 > qf_q || t > s) begin
										sv_q[s] <= 1'b1;
									end
								end
							end
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// File: rtl/core/triangle_edge_adjacency.sv
// triangle_edge_adjacency: clear, append, unused op: front queue, then result register
// read of a stored face: BK_QLOAD, then BK_SCAN over all faces, one face ram read per cycle
// throughput: one item per cycle for clear and append while results are popped
// read of an absent face: no scan; a read holds the back end for its whole scan
// reset: asynchronous, empties both queues and sets face_count to zero; no clearing pass
module triangle_edge_adjacency #(
	parameter int MAX_FACES   = 4096,
	parameter int VERTEX_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  tea_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output tea_pkg::out_item_t result
);
	import tea_pkg::*;

	// classified item handed from front to back
	cmd_link_t link;
	logic      cmd_pop;

	// front: takes items and classifies them by operation into a short queue
	tea_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.link    (link),
		.cmd_pop (cmd_pop)
	);

	// back: owns the face ram and the face count, scans faces on a read and
	// keeps the finished result item in an output register
	tea_back #(
		.MAX_FACES   (MAX_FACES),
		.VERTEX_BITS (VERTEX_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.link    (link),
		.cmd_pop (cmd_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);
endmodule

// File: rtl/core/tea_checker.sv
// tea_checker: port level assertions of triangle_edge_adjacency, with its bind
// depends on tea_pkg
module tea_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input tea_pkg::in_item_t  item,
	input logic               empty,
	input logic               pop,
	input tea_pkg::out_item_t result
);
	import tea_pkg::*;

	// no result item straight out of reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result shown during reset");

	// a waiting result item holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed");

	// status is never the unused code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.status != 2'd3))
		else $error("bad status code");

	// dropped append names face zero
	a_full_face: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == ST_FULL) |-> (result.face_number == 12'd0))
		else $error("dropped append with nonzero face");
endmodule

bind triangle_edge_adjacency tea_checker u_chk (.*);
